// ===== sv/strp_pkg.sv =====
// Shared constants and character tables for the SNTP time reply parser.
// No dependencies; imported by sntp_time_reply_parser_core.
package strp_pkg;

  localparam int unsigned PREFIX_LEN = 13;
  localparam int unsigned PREFIX_POS_W = $clog2(PREFIX_LEN + 1);

  localparam logic [15:0] MIN_YEAR_RESET = 16'd2024;
  localparam logic [7:0] MAX_DAY = 8'd31;
  localparam logic [7:0] MAX_HOUR = 8'd23;
  localparam logic [7:0] MAX_MINUTE = 8'd59;
  localparam logic [7:0] MAX_SECOND = 8'd59;
  localparam logic [3:0] MAX_MONTH = 4'd12;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam int unsigned RESULT_DATA_W = 56;

  function automatic logic [7:0] prefix_char(input logic [PREFIX_POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0: c = "+";
      4'd1: c = "C";
      4'd2: c = "I";
      4'd3: c = "P";
      4'd4: c = "S";
      4'd5: c = "N";
      4'd6: c = "T";
      4'd7: c = "P";
      4'd8: c = "T";
      4'd9: c = "I";
      4'd10: c = "M";
      4'd11: c = "E";
      4'd12: c = ":";
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

  function automatic logic is_white(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic logic [2:0] weekday_code(input logic [23:0] name);
    logic [2:0] code;
    case (name)
      "Mon": code = 3'd1;
      "Tue": code = 3'd2;
      "Wed": code = 3'd3;
      "Thu": code = 3'd4;
      "Fri": code = 3'd5;
      "Sat": code = 3'd6;
      "Sun": code = 3'd7;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] month_code(input logic [23:0] name);
    logic [3:0] code;
    case (name)
      "Jan": code = 4'd1;
      "Feb": code = 4'd2;
      "Mar": code = 4'd3;
      "Apr": code = 4'd4;
      "May": code = 4'd5;
      "Jun": code = 4'd6;
      "Jul": code = 4'd7;
      "Aug": code = 4'd8;
      "Sep": code = 4'd9;
      "Oct": code = 4'd10;
      "Nov": code = 4'd11;
      "Dec": code = 4'd12;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/sntp_time_reply_parser_core.sv =====
// SNTP time reply parser: byte stream in, one time record per response out.
// Depends on strp_pkg for character tables and limits.
// When its last byte is accepted, a record is registered into the output register, or into the skid stage if held.
// Throughput: one byte per cycle while s_axis_tready is high; the parse state updates in a single pass per byte.
// s_axis_tready drops only while both the output register and the skid stage hold records.
// Reset: parse state cleared to prefix search, min_year set to 2024, no pending records.
module sntp_time_reply_parser_core
  import strp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [15:0]              cfg_wr_data,   // min_year
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // data_byte
  input  logic                     s_axis_tlast,  // last_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // weekday[2:0], month[6:3], day[14:7], hour[22:15], minute[30:23], second[38:31],
  // year[54:39], zero fill[55]
  output logic [RESULT_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]               m_axis_tuser   // time_valid
);

  typedef enum logic [3:0] {
    PH_SEARCH  = 4'd0,
    PH_WDAY    = 4'd1,
    PH_MON     = 4'd2,
    PH_DAY     = 4'd3,
    PH_HOUR    = 4'd4,
    PH_COLON_A = 4'd5,
    PH_MIN     = 4'd6,
    PH_COLON_B = 4'd7,
    PH_SEC     = 4'd8,
    PH_YEAR    = 4'd9,
    PH_DONE    = 4'd10,
    PH_STOP    = 4'd11
  } phase_t;

  logic [15:0]             min_year;
  phase_t                  phase, phase_next;
  logic [PREFIX_POS_W-1:0] prefix_pos, prefix_pos_next;
  logic [7:0]              tok0, tok0_next, tok1, tok1_next, tok2, tok2_next;
  logic [1:0]              tok_len, tok_len_next;
  logic [15:0]             acc, acc_next;
  logic [2:0]              wday, wday_next;
  logic [3:0]              mon, mon_next;
  logic [7:0]              day, day_next, hour, hour_next;
  logic [7:0]              minute, minute_next, second, second_next;
  logic [15:0]             year, year_next;
  logic                    failed, failed_next;

  logic                    skid_valid;
  logic [RESULT_DATA_W-1:0] skid_tdata;
  logic                    skid_tuser;

  logic                    accept;
  logic                    byte_white;
  logic                    byte_digit;
  logic [3:0]              digit_val;
  logic [15:0]             acc_mul;
  logic                    res_valid;
  logic [RESULT_DATA_W-1:0] res_data;
  logic                    time_ok;

  assign s_axis_tready = !skid_valid;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign byte_white = is_white(s_axis_tdata);
  assign byte_digit = (s_axis_tdata >= CHAR_ZERO) && (s_axis_tdata <= CHAR_NINE);
  assign digit_val = 4'(s_axis_tdata - CHAR_ZERO);
  assign acc_mul = 16'((acc << 3) + (acc << 1) + {12'd0, digit_val});

  always_comb begin
    phase_next = phase;
    prefix_pos_next = prefix_pos;
    tok0_next = tok0;
    tok1_next = tok1;
    tok2_next = tok2;
    tok_len_next = tok_len;
    acc_next = acc;
    wday_next = wday;
    mon_next = mon;
    day_next = day;
    hour_next = hour;
    minute_next = minute;
    second_next = second;
    year_next = year;
    failed_next = failed;
    res_valid = 1'b0;
    res_data = '0;
    time_ok = 1'b0;

    if (accept && s_axis_tdata != CHAR_NUL) begin
      case (phase)
        PH_SEARCH: begin
          if (s_axis_tdata == prefix_char(prefix_pos)) begin
            prefix_pos_next = prefix_pos + 1'b1;
            if (prefix_pos_next == PREFIX_POS_W'(PREFIX_LEN)) begin
              phase_next = PH_WDAY;
              tok_len_next = 2'd0;
            end
          end else begin
            prefix_pos_next = (s_axis_tdata == CHAR_PLUS) ? PREFIX_POS_W'(1) : '0;
          end
        end
        PH_WDAY, PH_MON: begin
          if (tok_len == 2'd0) begin
            if (!byte_white) begin
              tok0_next = s_axis_tdata;
              tok_len_next = 2'd1;
            end
          end else if (tok_len != 2'd3 && !byte_white) begin
            if (tok_len == 2'd1) begin
              tok1_next = s_axis_tdata;
            end else begin
              tok2_next = s_axis_tdata;
            end
            tok_len_next = tok_len + 2'd1;
          end else begin
            tok_len_next = 2'd0;
            if (phase == PH_WDAY) begin
              wday_next = (tok_len == 2'd3) ? weekday_code({tok0, tok1, tok2}) : 3'd0;
              phase_next = PH_MON;
              if (!byte_white) begin
                tok0_next = s_axis_tdata;
                tok_len_next = 2'd1;
              end
            end else begin
              mon_next = (tok_len == 2'd3) ? month_code({tok0, tok1, tok2}) : 4'd0;
              phase_next = PH_DAY;
              if (byte_digit) begin
                acc_next = {12'd0, digit_val};
                tok_len_next = 2'd1;
              end else if (!byte_white) begin
                failed_next = 1'b1;
                phase_next = PH_STOP;
              end
            end
          end
        end
        PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_YEAR: begin
          if (byte_digit) begin
            acc_next = (tok_len != 2'd0) ? acc_mul : {12'd0, digit_val};
            tok_len_next = 2'd1;
          end else if (tok_len == 2'd0) begin
            if (!byte_white) begin
              failed_next = 1'b1;
              phase_next = PH_STOP;
            end
          end else begin
            tok_len_next = 2'd0;
            acc_next = '0;
            case (phase)
              PH_DAY: begin
                day_next = acc[7:0];
                phase_next = PH_HOUR;
              end
              PH_HOUR: begin
                hour_next = acc[7:0];
                phase_next = PH_COLON_A;
              end
              PH_MIN: begin
                minute_next = acc[7:0];
                phase_next = PH_COLON_B;
              end
              PH_SEC: begin
                second_next = acc[7:0];
                phase_next = PH_YEAR;
              end
              default: begin
                year_next = acc;
                phase_next = PH_DONE;
              end
            endcase
            if (phase == PH_DAY || phase == PH_SEC) begin
              if (!byte_white) begin
                failed_next = 1'b1;
                phase_next = PH_STOP;
              end
            end else if (phase == PH_HOUR || phase == PH_MIN) begin
              if (s_axis_tdata == CHAR_COLON) begin
                phase_next = (phase == PH_HOUR) ? PH_MIN : PH_SEC;
              end else begin
                failed_next = 1'b1;
                phase_next = PH_STOP;
              end
            end
          end
        end
        PH_COLON_A, PH_COLON_B: begin
          if (s_axis_tdata == CHAR_COLON) begin
            phase_next = (phase == PH_COLON_A) ? PH_MIN : PH_SEC;
            tok_len_next = 2'd0;
          end else begin
            failed_next = 1'b1;
            phase_next = PH_STOP;
          end
        end
        default: begin
        end
      endcase
    end

    if (accept && (s_axis_tdata == CHAR_NUL || s_axis_tlast)) begin
      if (phase_next == PH_YEAR && tok_len_next != 2'd0) begin
        year_next = acc_next;
        tok_len_next = 2'd0;
        acc_next = '0;
        phase_next = PH_DONE;
      end
      if (phase_next != PH_DONE) begin
        phase_next = PH_STOP;
      end
    end

    if (accept && s_axis_tlast) begin
      time_ok = (phase_next == PH_DONE) && !failed_next &&
                (wday_next != 3'd0) && (mon_next != 4'd0) && (mon_next <= MAX_MONTH) &&
                (year_next >= min_year) &&
                (day_next != 8'd0) && (day_next <= MAX_DAY) &&
                (hour_next <= MAX_HOUR) && (minute_next <= MAX_MINUTE) &&
                (second_next <= MAX_SECOND);
      res_valid = time_ok;
      if (time_ok) begin
        res_data = {1'b0, year_next, second_next, minute_next, hour_next, day_next,
                    mon_next, wday_next};
      end
      phase_next = PH_SEARCH;
      prefix_pos_next = '0;
      tok0_next = '0;
      tok1_next = '0;
      tok2_next = '0;
      tok_len_next = 2'd0;
      acc_next = '0;
      wday_next = '0;
      mon_next = '0;
      day_next = '0;
      hour_next = '0;
      minute_next = '0;
      second_next = '0;
      year_next = '0;
      failed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RESET;
      phase <= PH_SEARCH;
      prefix_pos <= '0;
      tok0 <= '0;
      tok1 <= '0;
      tok2 <= '0;
      tok_len <= 2'd0;
      acc <= '0;
      wday <= '0;
      mon <= '0;
      day <= '0;
      hour <= '0;
      minute <= '0;
      second <= '0;
      year <= '0;
      failed <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_year <= cfg_wr_data;
      end
      phase <= phase_next;
      prefix_pos <= prefix_pos_next;
      tok0 <= tok0_next;
      tok1 <= tok1_next;
      tok2 <= tok2_next;
      tok_len <= tok_len_next;
      acc <= acc_next;
      wday <= wday_next;
      mon <= mon_next;
      day <= day_next;
      hour <= hour_next;
      minute <= minute_next;
      second <= second_next;
      year <= year_next;
      failed <= failed_next;
    end
  end

  // Output register with a one-word skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept && s_axis_tlast) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready && !skid_valid) begin
        m_axis_tvalid <= 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        skid_valid <= 1'b0;
      end else if (accept && s_axis_tlast && m_axis_tvalid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready && skid_valid) begin
      m_axis_tdata <= skid_tdata;
      m_axis_tuser <= skid_tuser;
    end else if (accept && s_axis_tlast) begin
      if (m_axis_tvalid && !m_axis_tready) begin
        skid_tdata <= res_data;
        skid_tuser <= res_valid;
      end else begin
        m_axis_tdata <= res_data;
        m_axis_tuser <= res_valid;
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> m_axis_tvalid)
    else $error("skid stage holds a word while output register is empty");

  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
    else $error("last byte accepted but no record presented");

  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
      (phase == PH_SEARCH && prefix_pos == '0 && !failed))
    else $error("parse state not cleared after last byte");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("invalid record carries nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[2:0] != 3'd0 && m_axis_tdata[6:3] != 4'd0 &&
       m_axis_tdata[6:3] <= MAX_MONTH && m_axis_tdata[14:7] != 8'd0))
    else $error("valid record with out-of-range weekday, month or day");
`endif

endmodule
